// ===== rtl/core/tvc_pkg.sv =====
// ----------------------------------------------------------------------------
// tvc_pkg: shared types and constants
// Widths, viewport scales and codes for the vertex transform and cull block.
// ----------------------------------------------------------------------------
`default_nettype none

package tvc_pkg;

  localparam int HALF_WIDTH  = 160;
  localparam int HALF_HEIGHT = 120;
  localparam int FRAC_BITS   = 16;
  localparam int W_EPS       = (1 << FRAC_BITS) / 10000;

  localparam int NUM_REGS = 8;
  localparam int COEF_W   = 32;
  localparam int VTX_W    = 8;
  localparam int MUL_W    = COEF_W + VTX_W + 1;  // coef times 9-bit signed vertex
  localparam int CLIP_W   = MUL_W + 2;           // three products plus bias
  localparam int NUM_W    = CLIP_W + 1;          // cx + cw and friends
  localparam int SCL_W    = 14;                  // signed viewport scale
  localparam int SN_W     = NUM_W + SCL_W;       // scaled numerator
  localparam int DEN_W    = CLIP_W - 1;          // positive w magnitude
  localparam int QB       = 15;                  // quotient magnitude bits
  localparam int SCR_W    = 16;
  localparam int DIV_LAT  = QB + 1;

  typedef logic [3:0][3:0][COEF_W-1:0] coef_mat_t;

  typedef struct packed {
    logic signed [CLIP_W-1:0] cx;
    logic signed [CLIP_W-1:0] cy;
    logic signed [CLIP_W-1:0] cz;
    logic signed [CLIP_W-1:0] cw;
  } clip_t;

  typedef enum logic [1:0] {
    ST_DRAWN   = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_DEGEN   = 2'd2
  } cull_e;

endpackage

`default_nettype wire

// ===== rtl/core/triangle_vertex_transform_cull.sv =====
// ----------------------------------------------------------------------------
// triangle_vertex_transform_cull: vertex transform, frustum cull, viewport
// Three transform lanes, a merge stage for plane and w tests, six dividers.
//
//   channel   dir  beat contents
//   s_axis    in   three vertices x,y,z (8b each) and color
//   m_axis    out  six screen coords, color; tuser = cull status
//   apb       in   eight 64-bit matrix registers at 8*i
//
// One triangle per cycle while m_axis_tready does not hold the pipeline.
// Stages in order: the lane multiply and row sums, the merge and viewport
// scale, the divider pipeline (a sign and range stage, then one quotient
// bit per stage), and the output register.
// The whole pipeline holds while a result waits on m_axis_tready.
// Reset clears the matrix and all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_vertex_transform_cull (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z, tri_color (8b each, lowest first)
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [79:0]  s_axis_tdata,
  // screen_x_first, screen_y_first, screen_x_second, screen_y_second,
  // screen_x_third, screen_y_third (16b each), out_color (8b)
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [103:0]      m_axis_tdata,
  // cull_status (2b)
  output logic [1:0]        m_axis_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import tvc_pkg::*;

  localparam logic signed [SCL_W-1:0] HW_S = SCL_W'(HALF_WIDTH);
  localparam logic signed [SCL_W-1:0] HH_S = SCL_W'(HALF_HEIGHT);
  localparam logic signed [CLIP_W-1:0] EPS_S = CLIP_W'(W_EPS);

  logic [63:0] cfg_q [NUM_REGS];
  coef_mat_t   mat;
  logic        en;

  // configuration
  assign pready = 1'b1;
  assign prdata = cfg_q[paddr[5:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      cfg_q[paddr[5:3]] <= pwdata;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = cfg_q[2*r][31:0];
      mat[r][1] = cfg_q[2*r][63:32];
      mat[r][2] = cfg_q[2*r+1][31:0];
      mat[r][3] = cfg_q[2*r+1][63:32];
    end
  end

  // advance everything whenever the output register can take a beat
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // lanes
  clip_t clip [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tvc_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .mat_i  (mat),
      .vx_i   (s_axis_tdata[24*k +: 8]),
      .vy_i   (s_axis_tdata[24*k + 8 +: 8]),
      .vz_i   (s_axis_tdata[24*k + 16 +: 8]),
      .clip_o (clip[k])
    );
  end

  logic       va_q, vb_q, vc_q;
  logic [7:0] col_a_q, col_b_q, col_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col_a_q <= s_axis_tdata[79:72];
      col_b_q <= col_a_q;
      col_c_q <= col_b_q;
    end
  end

  // merge: plane tests, w test, viewport scale
  logic [2:0] f_l, f_r, f_b, f_t, f_n, f_f, f_d;
  logic signed [NUM_W-1:0] nx [3];
  logic signed [NUM_W-1:0] ny [3];
  logic signed [NUM_W-1:0] dz [3];
  logic signed [NUM_W-1:0] dxr [3];
  logic signed [NUM_W-1:0] cw_e [3];
  cull_e status_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cw_e[k] = NUM_W'(clip[k].cw);
      nx[k]   = NUM_W'(clip[k].cx) + cw_e[k];
      dxr[k]  = cw_e[k] - NUM_W'(clip[k].cx);
      ny[k]   = cw_e[k] - NUM_W'(clip[k].cy);
      dz[k]   = cw_e[k] - NUM_W'(clip[k].cz);
      f_l[k]  = nx[k][NUM_W-1];
      f_r[k]  = dxr[k][NUM_W-1];
      f_b[k]  = (NUM_W'(clip[k].cy) + cw_e[k]) < 0;
      f_t[k]  = ny[k][NUM_W-1];
      f_n[k]  = clip[k].cz[CLIP_W-1];
      f_f[k]  = dz[k][NUM_W-1];
      f_d[k]  = clip[k].cw <= EPS_S;
    end
    if ((&f_l) || (&f_r) || (&f_b) || (&f_t) || (&f_n) || (&f_f)) begin
      status_d = ST_OUTSIDE;
    end else if (|f_d) begin
      status_d = ST_DEGEN;
    end else begin
      status_d = ST_DRAWN;
    end
  end

  logic signed [SN_W-1:0] sn_q [6];
  logic [DEN_W-1:0]       den_q [3];
  cull_e                  st_c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sn_q[2*k]   <= nx[k] * HW_S;
        sn_q[2*k+1] <= ny[k] * HH_S;
        den_q[k]    <= clip[k].cw[DEN_W-1:0];
      end
      st_c_q <= status_d;
    end
  end

  // dividers
  logic signed [SCR_W-1:0] quo [6];

  for (genvar j = 0; j < 6; j++) begin : g_div
    tvc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (sn_q[j]),
      .den_i (den_q[j/2]),
      .quo_o (quo[j])
    );
  end

  // status and color ride alongside the dividers
  logic       vd_q  [DIV_LAT];
  cull_e      std_q [DIV_LAT];
  logic [7:0] cold_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      vd_q[0] <= vc_q;
      for (int i = 1; i < DIV_LAT; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      std_q[0]  <= st_c_q;
      cold_q[0] <= col_c_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        std_q[i]  <= std_q[i-1];
        cold_q[i] <= cold_q[i-1];
      end
    end
  end

  // output register
  logic [SCR_W-1:0] scr_q [6];
  logic [7:0]       ocol_q;
  cull_e            ost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vd_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        // zero the coordinates of culled or degenerate triangles
        scr_q[j] <= (std_q[DIV_LAT-1] == ST_DRAWN) ? quo[j] : '0;
      end
      ocol_q <= cold_q[DIV_LAT-1];
      ost_q  <= std_q[DIV_LAT-1];
    end
  end

  assign m_axis_tdata = {ocol_q, scr_q[5], scr_q[4], scr_q[3],
                         scr_q[2], scr_q[1], scr_q[0]};
  assign m_axis_tuser = ost_q;

endmodule

`default_nettype wire

// ===== rtl/core/tvc_lane.sv =====
// ----------------------------------------------------------------------------
// tvc_lane: one vertex transform lane
// Multiplies a vertex (w = 1) by the 4x4 matrix; products, then row sums.
// ----------------------------------------------------------------------------
`default_nettype none

module tvc_lane (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire tvc_pkg::coef_mat_t       mat_i,
  input  wire logic [tvc_pkg::VTX_W-1:0] vx_i,
  input  wire logic [tvc_pkg::VTX_W-1:0] vy_i,
  input  wire logic [tvc_pkg::VTX_W-1:0] vz_i,
  output tvc_pkg::clip_t                clip_o
);
  import tvc_pkg::*;

  logic signed [MUL_W-1:0]  prod_q [4][3];
  logic signed [COEF_W-1:0] bias_q [4];
  logic signed [CLIP_W-1:0] sum_q  [4];
  logic signed [VTX_W:0]    vs [3];

  assign vs[0] = $signed({1'b0, vx_i});
  assign vs[1] = $signed({1'b0, vy_i});
  assign vs[2] = $signed({1'b0, vz_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(mat_i[r][c]) * vs[c];
        end
        bias_q[r] <= $signed(mat_i[r][3]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        sum_q[r] <= CLIP_W'(prod_q[r][0]) + CLIP_W'(prod_q[r][1])
                  + CLIP_W'(prod_q[r][2]) + CLIP_W'(bias_q[r]);
      end
    end
  end

  assign clip_o.cx = sum_q[0];
  assign clip_o.cy = sum_q[1];
  assign clip_o.cz = sum_q[2];
  assign clip_o.cw = sum_q[3];

endmodule

`default_nettype wire

// ===== rtl/core/tvc_div.sv =====
// ----------------------------------------------------------------------------
// tvc_div: pipelined saturating divider
// Signed numerator over positive w, truncated toward zero, clipped to 16 bits.
// One stage for sign and range check, then one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tvc_div (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [tvc_pkg::SN_W-1:0] num_i,
  input  wire logic [tvc_pkg::DEN_W-1:0]       den_i,
  output logic signed [tvc_pkg::SCR_W-1:0]     quo_o
);
  import tvc_pkg::*;

  logic [SN_W-1:0]  rem_q [DIV_LAT];
  logic [QB-1:0]    quo_q [DIV_LAT];
  logic [DEN_W-1:0] den_q [DIV_LAT];
  logic             neg_q [DIV_LAT];
  logic             sat_q [DIV_LAT];
  logic [SN_W-1:0]  mag;
  logic [SN_W-1:0]  lim;

  assign mag = num_i[SN_W-1] ? SN_W'(-num_i) : SN_W'(num_i);
  assign lim = {{(SN_W-DEN_W-QB){1'b0}}, den_i, {QB{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= mag;
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= num_i[SN_W-1];
      sat_q[0] <= (mag >= lim);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [SN_W-1:0] dsh;
    logic            ge;
    assign dsh = {{(SN_W-DEN_W){1'b0}}, den_q[s]} << (QB - 1 - s);
    assign ge  = rem_q[s] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? rem_q[s] - dsh : rem_q[s];
        quo_q[s+1] <= {quo_q[s][QB-2:0], ge};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        sat_q[s+1] <= sat_q[s];
      end
    end
  end

  always_comb begin
    if (sat_q[QB]) begin
      quo_o = neg_q[QB] ? {1'b1, {(SCR_W-1){1'b0}}} : {1'b0, {(SCR_W-1){1'b1}}};
    end else if (neg_q[QB]) begin
      quo_o = -$signed({1'b0, quo_q[QB]});
    end else begin
      quo_o = $signed({1'b0, quo_q[QB]});
    end
  end

endmodule

`default_nettype wire
